@@ design/ldd_pkg.sv @@
`timescale 1ns / 1ps

package ldd_pkg;

  localparam int THREADS  = 16;
  localparam int LOCKS    = 64;
  localparam int THREAD_W = 4;
  localparam int LOCK_W   = 6;
  localparam int MODE_W   = 2;

  typedef logic [THREAD_W-1:0] thread_t;
  typedef logic [LOCK_W-1:0]   lock_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_WAIT = 2'd0,
    MODE_ACQ  = 2'd1,
    MODE_REL  = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  typedef struct packed {
    logic    wait_set;
    logic    wait_clr;
    logic    own_set;
    logic    own_clr;
    thread_t th;
    lock_t   lk;
    logic    rd_en;
    thread_t rd_th;
  } tbl_cmd_t;

  typedef struct packed {
    logic    wait_valid;
    logic    own_valid;
    thread_t owner;
  } tbl_sts_t;

endpackage

@@ design/ldd_in_if.sv @@
`timescale 1ns / 1ps

interface ldd_in_if;
  logic                        valid;
  logic                        ready;
  logic [ldd_pkg::MODE_W-1:0]  mode;
  ldd_pkg::thread_t            thread_index;
  ldd_pkg::lock_t              lock_index;

  modport source (output valid, output mode, output thread_index, output lock_index,
                  input ready);
  modport sink   (input valid, input mode, input thread_index, input lock_index,
                  output ready);
endinterface

@@ design/ldd_out_if.sv @@
`timescale 1ns / 1ps

interface ldd_out_if;
  logic valid;
  logic ready;
  logic deadlock;

  modport source (output valid, output deadlock, input ready);
  modport sink   (input valid, input deadlock, output ready);
endinterface

@@ design/ldd_ram.sv @@
`timescale 1ns / 1ps

module ldd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/ldd_tables.sv @@
`timescale 1ns / 1ps

module ldd_tables (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ldd_pkg::tbl_cmd_t cmd_i,
  output ldd_pkg::tbl_sts_t sts_o
);
  import ldd_pkg::*;

  logic [THREADS-1:0] wait_valid_q;
  lock_t              wait_lock_q [THREADS];
  logic [LOCKS-1:0]   owner_valid_q;
  lock_t              rd_lock;
  thread_t            owner;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_valid_q  <= '0;
      owner_valid_q <= '0;
    end else begin
      if (cmd_i.wait_set) begin
        wait_valid_q[cmd_i.th] <= 1'b1;
      end else if (cmd_i.wait_clr) begin
        wait_valid_q[cmd_i.th] <= 1'b0;
      end
      if (cmd_i.own_set) begin
        owner_valid_q[cmd_i.lk] <= 1'b1;
      end else if (cmd_i.own_clr) begin
        owner_valid_q[cmd_i.lk] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wait_set) begin
      wait_lock_q[cmd_i.th] <= cmd_i.lk;
    end
  end

  assign rd_lock = wait_lock_q[cmd_i.rd_th];

  ldd_ram #(
    .WIDTH(THREAD_W),
    .DEPTH(LOCKS)
  ) u_owner_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.own_set),
    .waddr_i(cmd_i.lk),
    .wdata_i(cmd_i.th),
    .re_i   (cmd_i.rd_en),
    .raddr_i(rd_lock),
    .rdata_o(owner)
  );

  always_comb begin
    sts_o.wait_valid = wait_valid_q[cmd_i.rd_th];
    sts_o.own_valid  = owner_valid_q[rd_lock];
    sts_o.owner      = owner;
  end

endmodule

@@ design/lock_wait_deadlock_detector_unit.sv @@
`timescale 1ns / 1ps

// Wait-for-graph deadlock detector. Each transfer on in_i is one lock event
// (wait request, acquire, release) and yields exactly one transfer on out_o
// carrying the deadlock flag. Acquire, release and unused modes go straight
// to the done state. A wait request walks the chain thread -> awaited lock ->
// owner, one hop per walk and fetch state (table lookup, then the registered
// read of the owner memory), for at most 16 hops. The input is not ready
// while a walk runs; a finished result waits in the output register without
// blocking the next transfer. The table valid flags are cleared by reset.
module lock_wait_deadlock_detector_unit (
  input logic  clk_i,
  input logic  rst_ni,
  ldd_in_if.sink    in_i,
  ldd_out_if.source out_o
);
  import ldd_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_FETCH = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state_q, state_d;
  thread_t    start_q, start_d;
  thread_t    cur_q, cur_d;
  thread_t    hop_q, hop_d;
  logic       dl_q, dl_d;
  logic       out_valid_q, out_valid_d;
  logic       out_dl_q, out_dl_d;
  logic       in_xfer;
  tbl_cmd_t   cmd;
  tbl_sts_t   sts;

  assign in_i.ready   = (state_q == ST_IDLE);
  assign in_xfer      = in_i.valid && in_i.ready;
  assign out_o.valid    = out_valid_q;
  assign out_o.deadlock = out_dl_q;

  ldd_tables u_tables (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .sts_o (sts)
  );

  always_comb begin
    state_d     = state_q;
    start_d     = start_q;
    cur_d       = cur_q;
    hop_d       = hop_q;
    dl_d        = dl_q;
    out_valid_d = out_valid_q;
    out_dl_d    = out_dl_q;
    cmd         = '0;
    cmd.th      = start_q;
    cmd.rd_th   = cur_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          cmd.th  = in_i.thread_index;
          cmd.lk  = in_i.lock_index;
          dl_d    = 1'b0;
          state_d = ST_DONE;
          case (in_i.mode)
            MODE_WAIT: begin
              cmd.wait_set = 1'b1;
              start_d      = in_i.thread_index;
              cur_d        = in_i.thread_index;
              hop_d        = '0;
              state_d      = ST_WALK;
            end
            MODE_ACQ: begin
              cmd.wait_clr = 1'b1;
              cmd.own_set  = 1'b1;
            end
            MODE_REL: begin
              cmd.own_clr = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_WALK: begin
        if (!sts.wait_valid || !sts.own_valid) begin
          dl_d    = 1'b0;
          state_d = ST_DONE;
        end else begin
          cmd.rd_en = 1'b1;
          state_d   = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (sts.owner == start_q) begin
          cmd.wait_clr = 1'b1;
          dl_d         = 1'b1;
          state_d      = ST_DONE;
        end else if (hop_q == THREAD_W'(THREADS - 1)) begin
          dl_d    = 1'b0;
          state_d = ST_DONE;
        end else begin
          hop_d   = hop_q + 1'b1;
          cur_d   = sts.owner;
          state_d = ST_WALK;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_dl_d    = dl_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q  <= start_d;
    cur_q    <= cur_d;
    hop_q    <= hop_d;
    dl_q     <= dl_d;
    out_dl_q <= out_dl_d;
  end

endmodule

@@ design/ldd_chk.sv @@
`timescale 1ns / 1ps

module ldd_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_deadlock_i
);

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] pend_q, pend_d;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  always_comb begin
    pend_d = pend_q;
    if (in_xfer && !out_xfer) begin
      pend_d = pend_q + 2'd1;
    end else if (!in_xfer && out_xfer) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  ap_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_i)
    else $error("input ready right after a transfer");

  ap_no_phantom_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 2'd0)
    else $error("result offered with no item outstanding");

  ap_two_outstanding_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 2'd2 |-> !in_ready_i && pend_q != 2'd3)
    else $error("input ready with two items outstanding");

  ap_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_deadlock_i))
    else $error("stalled result dropped or changed");

endmodule

bind lock_wait_deadlock_detector_unit ldd_chk u_ldd_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_deadlock_i(out_o.deadlock)
);
